FILE: rtl/core/pshd_pkg.sv
package pshd_pkg;

    localparam int ONE_Q14       = 16384;
    localparam int SPEC_EXPONENT = 32;
    localparam int EXP_BITS      = 9;
    localparam logic [EXP_BITS-1:0] SPEC_EXP_VEC = EXP_BITS'(SPEC_EXPONENT);

    localparam int POS_W  = 24;
    localparam int VEC_W  = 16;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 52;
    localparam int LEN_W  = SQ_W / 2;
    localparam int Q_W    = 15;
    localparam int UNIT_W = 15;

    localparam int AMB_MUL   = 205;
    localparam int AMB_SHIFT = 11;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int NUM_STAGES = 2 + LEN_W + Q_W + 6 + EXP_BITS + 2;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_POS_X = 3'd0,
        REG_POS_Y = 3'd1,
        REG_POS_Z = 3'd2,
        REG_RED   = 3'd3,
        REG_GREEN = 3'd4,
        REG_BLUE  = 3'd5,
        REG_ALPHA = 3'd6
    } reg_idx_t;

    localparam logic [POS_W-1:0] RST_POS_X = 24'd0;
    localparam logic [POS_W-1:0] RST_POS_Y = 24'd1280;
    localparam logic [POS_W-1:0] RST_POS_Z = 24'hFFF600;
    localparam logic [7:0]       RST_COLOR = 8'd255;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
    } light_t;

    typedef struct packed {
        logic [2:0][VEC_W-1:0]  n;
        logic [2:0][VEC_W-1:0]  v;
        logic [2:0][DIFF_W-1:0] d;
    } frag_item_t;

endpackage

FILE: rtl/core/pshd_frag_if.sv
interface pshd_frag_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
    logic signed [23:0] frag_x;
    logic signed [23:0] frag_y;
    logic signed [23:0] frag_z;

    modport source (
        output valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
               frag_x, frag_y, frag_z,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
               frag_x, frag_y, frag_z,
        output ready
    );
endinterface

FILE: rtl/core/pshd_pix_if.sv
interface pshd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

FILE: rtl/core/pshd_cfg.sv
module pshd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pshd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pshd_pkg::light_t            light
);

    pshd_pkg::light_t light_reg;
    pshd_pkg::light_t light_next;
    pshd_pkg::reg_idx_t idx;
    logic wr_en;

    assign idx    = pshd_pkg::reg_idx_t'(paddr[pshd_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign light  = light_reg;

    always_comb
    begin
        light_next = light_reg;
        if (wr_en)
        begin
            unique case (idx)
                pshd_pkg::REG_POS_X: light_next.pos_x = pwdata[23:0];
                pshd_pkg::REG_POS_Y: light_next.pos_y = pwdata[23:0];
                pshd_pkg::REG_POS_Z: light_next.pos_z = pwdata[23:0];
                pshd_pkg::REG_RED:   light_next.red   = pwdata[7:0];
                pshd_pkg::REG_GREEN: light_next.green = pwdata[7:0];
                pshd_pkg::REG_BLUE:  light_next.blue  = pwdata[7:0];
                pshd_pkg::REG_ALPHA: light_next.alpha = pwdata[7:0];
                default:             light_next = light_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pshd_pkg::REG_POS_X: prdata = {8'd0, light_reg.pos_x};
            pshd_pkg::REG_POS_Y: prdata = {8'd0, light_reg.pos_y};
            pshd_pkg::REG_POS_Z: prdata = {8'd0, light_reg.pos_z};
            pshd_pkg::REG_RED:   prdata = {24'd0, light_reg.red};
            pshd_pkg::REG_GREEN: prdata = {24'd0, light_reg.green};
            pshd_pkg::REG_BLUE:  prdata = {24'd0, light_reg.blue};
            pshd_pkg::REG_ALPHA: prdata = {24'd0, light_reg.alpha};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg.pos_x <= pshd_pkg::RST_POS_X;
            light_reg.pos_y <= pshd_pkg::RST_POS_Y;
            light_reg.pos_z <= pshd_pkg::RST_POS_Z;
            light_reg.red   <= pshd_pkg::RST_COLOR;
            light_reg.green <= pshd_pkg::RST_COLOR;
            light_reg.blue  <= pshd_pkg::RST_COLOR;
            light_reg.alpha <= pshd_pkg::RST_COLOR;
        end
        else
        begin
            light_reg <= light_next;
        end
    end

endmodule

FILE: rtl/core/pshd_front.sv
module pshd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pshd_pkg::light_t     light,
    pshd_frag_if.sink            frag,
    output logic                 item_valid,
    output pshd_pkg::frag_item_t item,
    input  logic                 item_ready
);

    logic                 valid_reg;
    pshd_pkg::frag_item_t item_reg;
    pshd_pkg::frag_item_t item_next;

    assign frag.ready = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_next.n[0] = frag.normal_x;
        item_next.n[1] = frag.normal_y;
        item_next.n[2] = frag.normal_z;
        item_next.v[0] = frag.view_x;
        item_next.v[1] = frag.view_y;
        item_next.v[2] = frag.view_z;
        item_next.d[0] = pshd_pkg::DIFF_W'($signed(light.pos_x))
                       - pshd_pkg::DIFF_W'(frag.frag_x);
        item_next.d[1] = pshd_pkg::DIFF_W'($signed(light.pos_y))
                       - pshd_pkg::DIFF_W'(frag.frag_y);
        item_next.d[2] = pshd_pkg::DIFF_W'($signed(light.pos_z))
                       - pshd_pkg::DIFF_W'(frag.frag_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (frag.ready)
        begin
            valid_reg <= frag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frag.valid && frag.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/core/pshd_fifo.sv
module pshd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  pshd_pkg::frag_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output pshd_pkg::frag_item_t pop_item
);

    pshd_pkg::frag_item_t mem [pshd_pkg::FIFO_DEPTH];
    logic [pshd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [pshd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [pshd_pkg::FIFO_CNT_W-1:0] cnt_reg;
    logic do_push;
    logic do_pop;

    assign push_ready = (cnt_reg != pshd_pkg::FIFO_CNT_W'(pshd_pkg::FIFO_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/pshd_back.sv
module pshd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pshd_pkg::light_t     light,
    input  logic                 item_valid,
    input  pshd_pkg::frag_item_t item,
    output logic                 item_pop,
    pshd_pix_if.source           pix
);

    localparam int NST = pshd_pkg::NUM_STAGES;
    localparam int LW  = pshd_pkg::LEN_W;
    localparam int SW  = pshd_pkg::SQ_W;
    localparam int QW  = pshd_pkg::Q_W;
    localparam int UW  = pshd_pkg::UNIT_W;
    localparam int EB  = pshd_pkg::EXP_BITS;

    typedef struct packed {
        logic [2:0][15:0] n;
        logic [2:0][15:0] v;
        logic [2:0][15:0] l;
        logic             zero;
    } ctx_t;

    logic adv;
    logic [NST-1:0] vld_reg;

    assign adv      = !vld_reg[NST-1] || pix.ready;
    assign item_pop = adv && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], item_valid};
        end
    end

    // squares and sum
    pshd_pkg::frag_item_t it0_reg;
    pshd_pkg::frag_item_t it1_reg;
    logic [49:0]          sq0_reg [3];
    logic [SW-1:0]        sum1_reg;
    logic signed [24:0]   dd [3];
    logic signed [49:0]   sqp [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd[i]  = $signed(item.d[i]);
            sqp[i] = 50'(dd[i]) * 50'(dd[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it0_reg <= item;
            for (int i = 0; i < 3; i++)
            begin
                sq0_reg[i] <= $unsigned(sqp[i]);
            end
            it1_reg  <= it0_reg;
            sum1_reg <= SW'(sq0_reg[0]) + SW'(sq0_reg[1]) + SW'(sq0_reg[2]);
        end
    end

    // square root, one result bit per stage
    logic [SW-1:0]        rad_reg  [LW];
    logic [LW+1:0]        rem_reg  [LW];
    logic [LW-1:0]        root_reg [LW];
    pshd_pkg::frag_item_t sit_reg  [LW];

    for (genvar k = 0; k < LW; k++)
    begin : g_sqrt
        logic [SW-1:0]        rad_in;
        logic [LW+1:0]        rem_in;
        logic [LW-1:0]        root_in;
        pshd_pkg::frag_item_t it_in;
        logic [LW+1:0]        rem_t;
        logic [LW+1:0]        trial;

        if (k == 0)
        begin : g_first
            assign rad_in  = sum1_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign it_in   = it1_reg;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign it_in   = sit_reg[k-1];
        end

        assign rem_t = {rem_in[LW-1:0], rad_in[SW-1:SW-2]};
        assign trial = {root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k] <= rad_in << 2;
                sit_reg[k] <= it_in;
                if (rem_t >= trial)
                begin
                    rem_reg[k]  <= rem_t - trial;
                    root_reg[k] <= {root_in[LW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_t;
                    root_reg[k] <= {root_in[LW-2:0], 1'b0};
                end
            end
        end
    end

    // division of each component by the length, one quotient bit per stage
    logic [LW:0]          dr_reg   [QW][3];
    logic [QW-1:0]        dq_reg   [QW][3];
    logic [LW-1:0]        dlen_reg [QW];
    pshd_pkg::frag_item_t dit_reg  [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [LW-1:0]        len_in;
        pshd_pkg::frag_item_t it_in;

        if (j == 0)
        begin : g_first
            assign len_in = root_reg[LW-1];
            assign it_in  = sit_reg[LW-1];
        end
        else
        begin : g_next
            assign len_in = dlen_reg[j-1];
            assign it_in  = dit_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dlen_reg[j] <= len_in;
                dit_reg[j]  <= it_in;
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [LW:0]   r_in;
            logic [QW-1:0] q_in;
            logic [24:0]   dmag;
            logic          ge;

            assign dmag = it_in.d[i][24] ? (25'd0 - it_in.d[i]) : it_in.d[i];

            if (j == 0)
            begin : g_first
                assign r_in = (LW+1)'(dmag);
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = {dr_reg[j-1][i][LW-1:0], 1'b0};
                assign q_in = dq_reg[j-1][i];
            end

            assign ge = (r_in >= {1'b0, len_in});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dr_reg[j][i] <= ge ? (r_in - {1'b0, len_in}) : r_in;
                    dq_reg[j][i] <= {q_in[QW-2:0], ge};
                end
            end
        end
    end

    // dot products, reflection, clamp
    ctx_t                cx_l;
    ctx_t                cx_l_reg;
    ctx_t                cx_d_reg;
    ctx_t                cx_rp_reg;
    logic signed [31:0]  pnl_reg [3];
    logic signed [19:0]  dot_reg;
    logic [UW-1:0]       diff_d_reg;
    logic [UW-1:0]       diff_rp_reg;
    logic [UW-1:0]       diff_r_reg;
    logic [UW-1:0]       diff_rvp_reg;
    logic [UW-1:0]       diff_rv_reg;
    logic signed [36:0]  rp_reg [3];
    logic signed [23:0]  r_reg [3];
    logic [2:0][15:0]    v_r_reg;
    logic                z_r_reg;
    logic signed [39:0]  rvp_reg [3];
    logic                z_rvp_reg;
    logic [UW-1:0]       s_reg;

    logic signed [33:0]  dot_sum;
    logic signed [19:0]  dot_c;
    logic signed [41:0]  rv_sum;
    logic signed [27:0]  rv_c;

    function automatic logic [14:0] clamp_unit(input logic signed [27:0] x);
        logic [14:0] y;
        if (x < 0)
        begin
            y = '0;
        end
        else if (x > 28'sd16384)
        begin
            y = 15'(pshd_pkg::ONE_Q14);
        end
        else
        begin
            y = x[14:0];
        end
        return y;
    endfunction

    always_comb
    begin
        cx_l.n    = dit_reg[QW-1].n;
        cx_l.v    = dit_reg[QW-1].v;
        cx_l.zero = (dlen_reg[QW-1] == '0);
        for (int i = 0; i < 3; i++)
        begin
            cx_l.l[i] = dit_reg[QW-1].d[i][24] ? (16'd0 - {1'b0, dq_reg[QW-1][i]})
                                               : {1'b0, dq_reg[QW-1][i]};
        end
        dot_sum = 34'(pnl_reg[0]) + 34'(pnl_reg[1]) + 34'(pnl_reg[2]);
        dot_c   = 20'(dot_sum >>> 14);
        rv_sum  = 42'(rvp_reg[0]) + 42'(rvp_reg[1]) + 42'(rvp_reg[2]);
        rv_c    = 28'(rv_sum >>> 14);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_l_reg <= cx_l;
            for (int i = 0; i < 3; i++)
            begin
                pnl_reg[i] <= 32'($signed(cx_l.n[i])) * 32'($signed(cx_l.l[i]));
            end

            cx_d_reg   <= cx_l_reg;
            dot_reg    <= dot_c;
            diff_d_reg <= cx_l_reg.zero ? '0 : clamp_unit(28'(dot_c));

            cx_rp_reg   <= cx_d_reg;
            diff_rp_reg <= diff_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                rp_reg[i] <= 37'($signed({dot_reg, 1'b0})) * 37'($signed(cx_d_reg.n[i]));
            end

            v_r_reg    <= cx_rp_reg.v;
            z_r_reg    <= cx_rp_reg.zero;
            diff_r_reg <= diff_rp_reg;
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= 24'(rp_reg[i] >>> 14) - 24'($signed(cx_rp_reg.l[i]));
            end

            z_rvp_reg    <= z_r_reg;
            diff_rvp_reg <= diff_r_reg;
            for (int i = 0; i < 3; i++)
            begin
                rvp_reg[i] <= 40'(r_reg[i]) * 40'($signed(v_r_reg[i]));
            end

            diff_rv_reg <= diff_rvp_reg;
            s_reg       <= z_rvp_reg ? '0 : clamp_unit(rv_c);
        end
    end

    // specular power, one exponent bit per stage
    logic [UW-1:0] pres_reg  [EB];
    logic [UW-1:0] pbase_reg [EB];
    logic [UW-1:0] pdiff_reg [EB];

    for (genvar e = 0; e < EB; e++)
    begin : g_pow
        logic [UW-1:0] res_in;
        logic [UW-1:0] base_in;
        logic [UW-1:0] diff_in;
        logic [29:0]   mr;
        logic [29:0]   mb;

        if (e == 0)
        begin : g_first
            assign res_in  = UW'(pshd_pkg::ONE_Q14);
            assign base_in = s_reg;
            assign diff_in = diff_rv_reg;
        end
        else
        begin : g_next
            assign res_in  = pres_reg[e-1];
            assign base_in = pbase_reg[e-1];
            assign diff_in = pdiff_reg[e-1];
        end

        assign mr = 30'(res_in) * 30'(base_in);
        assign mb = 30'(base_in) * 30'(base_in);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pres_reg[e]  <= pshd_pkg::SPEC_EXP_VEC[e] ? mr[28:14] : res_in;
                pbase_reg[e] <= mb[28:14];
                pdiff_reg[e] <= diff_in;
            end
        end
    end

    // color terms and saturation
    logic [7:0]  col [3];
    logic [22:0] cd_reg [3];
    logic [22:0] cs_reg [3];
    logic [7:0]  amb_reg [3];
    logic [15:0] amb_p [3];
    logic [9:0]  tot [3];
    logic [7:0]  out_reg [3];

    always_comb
    begin
        col[0] = light.red;
        col[1] = light.green;
        col[2] = light.blue;
        for (int i = 0; i < 3; i++)
        begin
            amb_p[i] = 16'(col[i]) * 16'(pshd_pkg::AMB_MUL);
            tot[i]   = 10'(amb_reg[i]) + 10'(cd_reg[i][22:14]) + 10'(cs_reg[i][22:14]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cd_reg[i]  <= 23'(col[i]) * 23'(pdiff_reg[EB-1]);
                cs_reg[i]  <= 23'(col[i]) * 23'(pres_reg[EB-1]);
                amb_reg[i] <= 8'(amb_p[i] >> pshd_pkg::AMB_SHIFT);
                out_reg[i] <= (tot[i] > 10'd255) ? 8'd255 : tot[i][7:0];
            end
        end
    end

    assign pix.valid     = vld_reg[NST-1];
    assign pix.out_red   = out_reg[0];
    assign pix.out_green = out_reg[1];
    assign pix.out_blue  = out_reg[2];
    assign pix.out_alpha = light.alpha;

endmodule

FILE: rtl/core/phong_fragment_shader.sv
// Phong shader for one point light, one fragment per clock.
// frag (sink): normal and view vectors in Q2.14, fragment position in
//   signed Q16.8; a transaction completes when valid and ready are high.
// pix (source): shaded red, green, blue and the light's alpha.
// APB port: light position x/y/z and red/green/blue/alpha at 4*index;
//   pready is always high. Write only while no fragment is in flight.
// Throughput: one fragment per cycle, sustained while pix.ready stays high.
// Path: the input register hands over to the 4-entry queue, the queue
//   head enters the back, and the last of the 60 back stages drives
//   pix.valid (2 square/sum stages, 26 square root bits, 15 quotient
//   bits, 6 dot/reflection stages, 9 exponent stages, color,
//   saturation).
// Stall: when pix.ready is low with a pixel waiting, the back pipeline
//   holds; the queue then fills and frag.ready drops.
// Reset: pipeline and queue empty, light registers take their defaults
//   (position 0, 5.0, -10.0; all color channels 255).
module phong_fragment_shader (
    input  logic                        clk,
    input  logic                        rst_n,
    pshd_frag_if.sink                   frag,
    pshd_pix_if.source                  pix,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pshd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    pshd_pkg::light_t     light;
    logic                 f_valid;
    logic                 f_ready;
    pshd_pkg::frag_item_t f_item;
    logic                 q_valid;
    logic                 q_pop;
    pshd_pkg::frag_item_t q_item;

    pshd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .light   (light)
    );

    pshd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .light      (light),
        .frag       (frag),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (f_ready)
    );

    pshd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    pshd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .light      (light),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .pix        (pix)
    );

endmodule
